FILE: rtl/scm_pkg.sv
// Shared types, constants and helpers for the sample covariance matrix block.
`default_nettype none
package scm_pkg;

    localparam int MAX_ROWS_DEF = 1024;
    localparam int MAX_DIMS_DEF = 8;
    localparam int SAMPLE_W     = 16;
    localparam int MEAN_W       = 25;
    localparam int ACC_W        = 64;
    localparam int COV_W        = 50;
    localparam int DIM_IDX_W    = 3;
    localparam int CFG_W        = 4;
    localparam logic [CFG_W-1:0] DIMS_RESET = 4'd8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic sum_clear;   // clear the accumulator and the pipeline
        logic sum_issue;   // issue one row read for the sum pass
        logic mean_start;  // start dividing the dimension sum into a mean
        logic prod_issue;  // issue one row read for the product pass
        logic cov_start;   // start dividing the product sum by m
        logic [DIM_IDX_W-1:0] dim_a;
        logic [DIM_IDX_W-1:0] dim_b;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_empty;  // no read or product beat still in flight
        logic div_busy;    // divider working
        logic div_done;    // divider result valid this cycle
    } t_status;

endpackage
`default_nettype wire

FILE: rtl/sample_covariance_matrix.sv
// Top level: population covariance matrix over stored sample rows.
// Sequence: the final row starts K mean passes, each a sum over the rows and a divide,
// then K*K entry passes, each a product sum over the rows, a divide and an output beat.
// Throughput: one row per cycle while loading; input is stalled during computation.
// Each matrix entry is held in the output register until taken.
// Reset (synchronous, active low) empties the row store count and sets dims_in_use to 8.
`default_nettype none
module sample_covariance_matrix #(
    parameter int MAX_ROWS = scm_pkg::MAX_ROWS_DEF,
    parameter int MAX_DIMS = scm_pkg::MAX_DIMS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic signed [15:0] i_sample_0,
    input  wire logic signed [15:0] i_sample_1,
    input  wire logic signed [15:0] i_sample_2,
    input  wire logic signed [15:0] i_sample_3,
    input  wire logic signed [15:0] i_sample_4,
    input  wire logic signed [15:0] i_sample_5,
    input  wire logic signed [15:0] i_sample_6,
    input  wire logic signed [15:0] i_sample_7,
    input  wire logic        i_final_row,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_entry_row,
    output logic [2:0]       o_entry_col,
    output logic signed [49:0] o_covariance,
    output logic             o_last_entry,
    output logic             o_rows_dropped
);
    import scm_pkg::*;

    localparam int ADDR_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W  = $clog2(MAX_ROWS + 1) + 1;

    logic [CFG_W-1:0]          r_dims;
    logic [ADDR_W-1:0]         w_wr_addr, w_rd_addr;
    logic                      w_wr_en;
    logic [CNT_W-1:0]          w_m;
    t_cmd                      w_cmd;
    t_status                   w_status;
    logic signed [COV_W-1:0]   w_cov;
    logic [8*SAMPLE_W-1:0]     w_row;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dims <= DIMS_RESET;
        else if (psel && penable && pwrite && paddr == 1'b0) r_dims <= pwdata[CFG_W-1:0];
    end
    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {{(32-CFG_W){1'b0}}, r_dims} : 32'd0;

    assign w_row = {i_sample_7, i_sample_6, i_sample_5, i_sample_4,
                    i_sample_3, i_sample_2, i_sample_1, i_sample_0};

    scm_controller #(.MAX_ROWS(MAX_ROWS), .MAX_DIMS(MAX_DIMS),
                     .ADDR_W(ADDR_W), .CNT_W(CNT_W)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_final(i_final_row), .o_in_stall(o_stall),
        .i_dims(r_dims), .o_wr_en(w_wr_en), .o_wr_addr(w_wr_addr),
        .o_rd_addr(w_rd_addr), .o_m(w_m), .o_cmd(w_cmd), .i_status(w_status),
        .i_cov(w_cov), .o_out_valid(o_valid), .i_out_stall(i_stall),
        .o_row(o_entry_row), .o_col(o_entry_col), .o_cov(o_covariance),
        .o_last(o_last_entry), .o_dropped(o_rows_dropped)
    );

    scm_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_DIMS(MAX_DIMS),
                   .ADDR_W(ADDR_W), .CNT_W(CNT_W)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr_en(w_wr_en), .i_wr_addr(w_wr_addr),
        .i_wr_data(w_row[MAX_DIMS*SAMPLE_W-1:0]), .i_rd_addr(w_rd_addr), .i_m(w_m),
        .i_cmd(w_cmd), .o_status(w_status), .o_cov(w_cov)
    );

    // No input is taken while a result is pending.
    a_stall_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input open while result pending");
    // A held result does not change.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_covariance))
        else $error("result changed under stall");
    // The final entry closes the set and reopens input.
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last_entry |=> !o_stall)
        else $error("input not reopened after last entry");
endmodule
`default_nettype wire

FILE: rtl/scm_divider.sv
// Restoring divider: signed dividend over unsigned divisor, truncated toward zero.
`default_nettype none
module scm_divider #(
    parameter int DEN_W = 11
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic signed [scm_pkg::ACC_W-1:0] i_num,
    input  wire logic [DEN_W-1:0]               i_den,
    output logic                                o_busy,
    output logic                                o_done,
    output logic signed [scm_pkg::ACC_W-1:0]    o_quot
);
    import scm_pkg::*;

    localparam int CNT_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0] r_quo, n_quo;
    logic [ACC_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, r_done;
    logic [ACC_W:0]   w_shift, w_diff;

    // One quotient bit per cycle.
    always_comb begin
        w_shift = {r_rem[ACC_W-1:0], r_quo[ACC_W-1]};
        w_diff  = w_shift - {{(ACC_W+1-DEN_W){1'b0}}, r_den};
        n_quo   = {r_quo[ACC_W-2:0], ~w_diff[ACC_W]};
        n_rem   = w_diff[ACC_W] ? w_shift : w_diff;
        n_cnt   = r_cnt - CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ACC_W);
                r_neg  <= i_num[ACC_W-1];
                r_quo  <= i_num[ACC_W-1] ? ACC_W'(-i_num) : ACC_W'(i_num);
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= n_cnt;
                if (n_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_quo) : $signed(r_quo);
endmodule
`default_nettype wire

FILE: rtl/scm_datapath.sv
// Datapath: row memory, accumulate pipeline, means and the shared divider.
`default_nettype none
module scm_datapath #(
    parameter int MAX_ROWS = scm_pkg::MAX_ROWS_DEF,
    parameter int MAX_DIMS = scm_pkg::MAX_DIMS_DEF,
    parameter int ADDR_W   = 10,
    parameter int CNT_W    = 11
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_wr_en,
    input  wire logic [ADDR_W-1:0]                   i_wr_addr,
    input  wire logic [MAX_DIMS*scm_pkg::SAMPLE_W-1:0] i_wr_data,
    input  wire logic [ADDR_W-1:0]                   i_rd_addr,
    input  wire logic [CNT_W-1:0]                    i_m,
    input  wire scm_pkg::t_cmd                       i_cmd,
    output scm_pkg::t_status                         o_status,
    output logic signed [scm_pkg::COV_W-1:0]         o_cov
);
    import scm_pkg::*;

    localparam int ROW_W = MAX_DIMS * SAMPLE_W;
    localparam int DEV_W = MEAN_W + 2;

    logic [ROW_W-1:0] r_mem [MAX_ROWS];
    logic [ROW_W-1:0] r_rd_data;
    logic             r_v1, r_v2, r_v3;
    logic             r_mode1, r_mode2;
    logic signed [DEV_W-1:0]  r_da, r_db;
    logic signed [2*DEV_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [MEAN_W-1:0] r_mean [MAX_DIMS];
    logic signed [SAMPLE_W-1:0] w_xa, w_xb;
    logic signed [ACC_W-1:0]  w_num, w_quot;
    logic                     r_div_mean;
    logic [DIM_IDX_W-1:0]     r_div_dim;
    logic                     w_busy, w_done;

    // Row memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign w_xa = r_rd_data[32'(i_cmd.dim_a)*SAMPLE_W +: SAMPLE_W];
    assign w_xb = r_rd_data[32'(i_cmd.dim_b)*SAMPLE_W +: SAMPLE_W];

    // Full-width product of the two deviations.
    assign w_prod = r_da * r_db;

    // Read, deviation, product, accumulate pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.sum_clear) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
            r_acc <= '0;
        end else begin
            r_v1 <= i_cmd.sum_issue | i_cmd.prod_issue;
            r_mode1 <= i_cmd.prod_issue;
            r_v2 <= r_v1; r_mode2 <= r_mode1;
            r_v3 <= r_v2;
            if (r_mode1) begin
                r_da <= (DEV_W'(w_xa) <<< 8) - DEV_W'(r_mean[i_cmd.dim_a]);
                r_db <= (DEV_W'(w_xb) <<< 8) - DEV_W'(r_mean[i_cmd.dim_b]);
            end else begin
                r_da <= DEV_W'(w_xa);
                r_db <= '0;
            end
            r_prod <= r_mode2 ? ACC_W'(w_prod) : ACC_W'(r_da);
            if (r_v3) r_acc <= r_acc + r_prod;
        end
    end

    // The sum pass scales by 256 before the divide.
    assign w_num = i_cmd.mean_start ? (r_acc <<< 8) : r_acc;

    scm_divider #(.DEN_W(CNT_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mean_start | i_cmd.cov_start),
        .i_num   (w_num),
        .i_den   (i_m),
        .o_busy  (w_busy),
        .o_done  (w_done),
        .o_quot  (w_quot)
    );

    // Capture the mean into its slot when the divider finishes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mean_start | i_cmd.cov_start) begin
            r_div_mean <= i_cmd.mean_start;
            r_div_dim  <= i_cmd.dim_a;
        end
        if (w_done && r_div_mean) r_mean[r_div_dim] <= MEAN_W'(w_quot);
    end

    assign o_status.pipe_empty = ~(r_v1 | r_v2 | r_v3 | i_cmd.sum_issue | i_cmd.prod_issue);
    assign o_status.div_busy   = w_busy;
    assign o_status.div_done   = w_done;
    assign o_cov = COV_W'(w_quot);
endmodule
`default_nettype wire

FILE: rtl/scm_controller.sv
// Controller: load, mean pass, covariance pass and output sequencing.
`default_nettype none
module scm_controller #(
    parameter int MAX_ROWS = scm_pkg::MAX_ROWS_DEF,
    parameter int MAX_DIMS = scm_pkg::MAX_DIMS_DEF,
    parameter int ADDR_W   = 10,
    parameter int CNT_W    = 11
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_final,
    output logic                               o_in_stall,
    input  wire logic [scm_pkg::CFG_W-1:0]     i_dims,
    output logic                               o_wr_en,
    output logic [ADDR_W-1:0]                  o_wr_addr,
    output logic [ADDR_W-1:0]                  o_rd_addr,
    output logic [CNT_W-1:0]                   o_m,
    output scm_pkg::t_cmd                      o_cmd,
    input  wire scm_pkg::t_status              i_status,
    input  wire logic signed [scm_pkg::COV_W-1:0] i_cov,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [scm_pkg::DIM_IDX_W-1:0]      o_row,
    output logic [scm_pkg::DIM_IDX_W-1:0]      o_col,
    output logic signed [scm_pkg::COV_W-1:0]   o_cov,
    output logic                               o_last,
    output logic                               o_dropped
);
    import scm_pkg::*;

    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_SUM   = 7'b0000010,
        S_SDRN  = 7'b0000100,
        S_MDIV  = 7'b0001000,
        S_PROD  = 7'b0010000,
        S_CDIV  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0]     r_count;
    logic [ADDR_W-1:0]    r_idx;
    logic                 r_ovf;
    logic [DIM_IDX_W-1:0] r_a, r_b, w_kmax;
    logic [CFG_W-1:0]     w_k;
    logic                 w_acc, w_last_row, r_started;

    // Clamp the dimension count into 1..MAX_DIMS.
    always_comb begin
        w_k = i_dims;
        if (w_k == '0) w_k = CFG_W'(1);
        if (w_k > CFG_W'(MAX_DIMS)) w_k = CFG_W'(MAX_DIMS);
        w_kmax = DIM_IDX_W'(w_k - CFG_W'(1));
    end

    assign o_in_stall = (r_state != S_LOAD);
    assign w_acc      = i_in_valid && (r_state == S_LOAD);
    assign o_wr_en    = w_acc && (r_count < CNT_W'(MAX_ROWS));
    assign o_wr_addr  = r_count[ADDR_W-1:0];
    assign o_rd_addr  = r_idx;
    assign o_m        = r_count;
    assign w_last_row = ({{(CNT_W-ADDR_W){1'b0}}, r_idx} == r_count - CNT_W'(1));

    // Commands follow the state.
    always_comb begin
        o_cmd = '0;
        o_cmd.dim_a = r_a;
        o_cmd.dim_b = r_b;
        unique case (r_state)
            // Keep the accumulator clear so the first sum pass starts from zero.
            S_LOAD: o_cmd.sum_clear = 1'b1;
            S_SUM:  o_cmd.sum_issue = 1'b1;
            S_PROD: begin
                o_cmd.prod_issue = r_started;
                o_cmd.sum_clear  = ~r_started;
            end
            S_SDRN: o_cmd.mean_start = i_status.pipe_empty;
            S_CDIV: o_cmd.cov_start = i_status.pipe_empty && !i_status.div_busy
                                      && !i_status.div_done && r_started;
            default: ;
        endcase
        if (r_state == S_MDIV && i_status.div_done && r_a != w_kmax) o_cmd.sum_clear = 1'b1;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: if (w_acc && i_final) n_state = S_SUM;
            S_SUM:  if (w_last_row) n_state = S_SDRN;
            S_SDRN: if (i_status.pipe_empty) n_state = S_MDIV;
            S_MDIV: if (i_status.div_done) n_state = (r_a == w_kmax) ? S_PROD : S_SUM;
            S_PROD: if (r_started && w_last_row) n_state = S_CDIV;
            S_CDIV: if (i_status.div_done) n_state = S_OUT;
            S_OUT:  if (!i_out_stall) n_state = (r_a == w_kmax && r_b == w_kmax) ? S_LOAD : S_PROD;
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_idx   <= '0;
            r_a <= '0; r_b <= '0;
            r_started <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_LOAD: begin
                    if (o_wr_en) r_count <= r_count + CNT_W'(1);
                    else if (w_acc) r_ovf <= 1'b1;
                    r_idx <= '0; r_a <= '0; r_b <= '0; r_started <= 1'b0;
                end
                S_SUM: r_idx <= w_last_row ? '0 : r_idx + ADDR_W'(1);
                S_SDRN: ;
                S_MDIV: if (i_status.div_done && r_a != w_kmax) r_a <= r_a + DIM_IDX_W'(1);
                        else if (i_status.div_done) r_a <= '0;
                S_PROD: begin
                    if (!r_started) r_started <= 1'b1;
                    else r_idx <= w_last_row ? '0 : r_idx + ADDR_W'(1);
                end
                S_CDIV: begin
                    if (o_cmd.cov_start) r_started <= 1'b0;
                    else if (!i_status.div_busy && !i_status.div_done && !r_started)
                        r_started <= 1'b0;
                    if (i_status.div_done) begin
                        o_cov  <= i_cov;
                        o_row  <= r_a;
                        o_col  <= r_b;
                        o_last <= (r_a == w_kmax) && (r_b == w_kmax);
                        o_dropped <= r_ovf;
                    end
                end
                S_OUT: if (!i_out_stall) begin
                    r_started <= 1'b0;
                    if (r_b == w_kmax) begin
                        r_b <= '0; r_a <= r_a + DIM_IDX_W'(1);
                    end else r_b <= r_b + DIM_IDX_W'(1);
                    if (n_state == S_LOAD) begin
                        r_count <= '0; r_ovf <= 1'b0;
                    end
                end
                default: ;
            endcase
            if (r_state == S_PROD && r_started && w_last_row) r_started <= 1'b1;
        end
    end

    assign o_out_valid = (r_state == S_OUT);
endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// Testbench for the sample covariance matrix block: random rows, live prediction, checks.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import scm_pkg::*;

    localparam int ROWS_CAP  = 1024;
    localparam int DIMS_CAP  = 8;
    localparam int CYCLE_CAP = 20000000;
    localparam logic [0:0] DIMS_ADDR = 1'b0;

    typedef struct packed {
        logic [7:0][15:0] smp;
        logic             fin;
    } row_beat_t;

    typedef struct packed {
        logic [2:0]  r;
        logic [2:0]  c;
        logic [49:0] cov;
        logic        last;
        logic        drop;
    } cov_entry_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [0:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic signed [15:0] smp_drv [8];
    logic        i_final_row = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_entry_row, o_entry_col;
    logic signed [49:0] o_covariance;
    logic        o_last_entry, o_rows_dropped;

    row_beat_t  row_queue [$];
    cov_entry_t cov_expect [$];
    logic signed [15:0] set_rows [ROWS_CAP][DIMS_CAP];
    int  set_count;
    bit  set_dropped;
    logic [3:0] dims_cfg;
    int  mismatches;
    int  cycles;
    int  rows_sent;
    bit  quiet;
    bit  beat_taken;
    int  send_gap, take_gap;

    initial for (int i = 0; i < 8; i++) smp_drv[i] = '0;

    always #4 i_clk = ~i_clk;

    sample_covariance_matrix dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_sample_0(smp_drv[0]), .i_sample_1(smp_drv[1]), .i_sample_2(smp_drv[2]),
        .i_sample_3(smp_drv[3]), .i_sample_4(smp_drv[4]), .i_sample_5(smp_drv[5]),
        .i_sample_6(smp_drv[6]), .i_sample_7(smp_drv[7]),
        .i_final_row(i_final_row),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_entry_row(o_entry_row), .o_entry_col(o_entry_col),
        .o_covariance(o_covariance), .o_last_entry(o_last_entry),
        .o_rows_dropped(o_rows_dropped)
    );

    task automatic report(input string what);
        mismatches++;
        $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    // Store one accepted row; on the final row compute the whole matrix.
    task automatic absorb_row(input row_beat_t b);
        int k, m;
        longint sum, acc, dr, dc, val;
        longint means [DIMS_CAP];
        cov_entry_t e;
        if (set_count < ROWS_CAP) begin
            for (int d = 0; d < DIMS_CAP; d++) set_rows[set_count][d] = b.smp[d];
            set_count++;
        end else begin
            set_dropped = 1'b1;
        end
        if (!b.fin) return;
        m = set_count;
        k = (dims_cfg == 0) ? 1 : (dims_cfg > DIMS_CAP) ? DIMS_CAP : dims_cfg;
        for (int d = 0; d < k; d++) begin
            sum = 0;
            for (int i = 0; i < m; i++) sum += longint'(set_rows[i][d]);
            means[d] = (sum * 256) / m;
        end
        for (int r = 0; r < k; r++) begin
            for (int c = 0; c < k; c++) begin
                acc = 0;
                for (int i = 0; i < m; i++) begin
                    dr = longint'(set_rows[i][r]) * 256 - means[r];
                    dc = longint'(set_rows[i][c]) * 256 - means[c];
                    acc += dr * dc;
                end
                val = acc / m;
                e.r = r[2:0];
                e.c = c[2:0];
                e.cov = val[49:0];
                e.last = (r == k - 1) && (c == k - 1);
                e.drop = set_dropped;
                cov_expect = {cov_expect, e};
            end
        end
        set_count = 0;
        set_dropped = 1'b0;
    endtask

    // Sender: a new beat goes out only once the previous one was taken.
    always @(negedge i_clk) begin
        row_beat_t b;
        logic v;
        v = i_valid;
        if (i_rst_n && (!i_valid || beat_taken)) begin
            v = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(0, 10);
            end else if (row_queue.size() > 0) begin
                b = row_queue.pop_front();
                for (int d = 0; d < 8; d++) smp_drv[d] <= b.smp[d];
                i_final_row <= b.fin;
                v = 1'b1;
            end
            i_valid <= v;
        end
    end

    // Receiver stall bursts.
    always @(negedge i_clk) begin
        if (take_gap > 0) begin
            take_gap--;
            i_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            take_gap = $urandom_range(0, 10);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Monitor: accept rows into the predictor and check each matrix entry beat.
    always @(posedge i_clk) begin
        row_beat_t b;
        cov_entry_t e;
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("TEST FAILED");
            $finish;
        end
        beat_taken = i_valid && !o_stall;
        if (beat_taken) begin
            for (int d = 0; d < 8; d++) b.smp[d] = smp_drv[d];
            b.fin = i_final_row;
            absorb_row(b);
        end
        if (o_valid && !i_stall) begin
            if (cov_expect.size() == 0) begin
                report("entry with nothing expected");
            end else begin
                e = cov_expect.pop_front();
                if (o_entry_row !== e.r)
                    report($sformatf("row %0d, expected %0d", o_entry_row, e.r));
                if (o_entry_col !== e.c)
                    report($sformatf("col %0d, expected %0d", o_entry_col, e.c));
                if (o_covariance !== e.cov)
                    report($sformatf("cov(%0d,%0d) %0d, expected %0d", e.r, e.c,
                                     o_covariance, $signed(e.cov)));
                if (o_last_entry !== e.last)
                    report($sformatf("last_entry %0b, expected %0b", o_last_entry, e.last));
                if (o_rows_dropped !== e.drop)
                    report($sformatf("rows_dropped %0b, expected %0b",
                                     o_rows_dropped, e.drop));
            end
        end
    end

    // Register write, setup then access cycle.
    task automatic write_dims(input logic [3:0] k);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= DIMS_ADDR;
        pwdata <= {28'd0, k};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        dims_cfg = k;
    endtask

    // Wait, checking just after each rising edge, until nothing is queued or in flight.
    task automatic settle;
        do begin
            @(posedge i_clk);
            #1;
        end while (row_queue.size() != 0 || cov_expect.size() != 0 || i_valid);
    endtask

    // Hold off until every queued row went out and every entry came back.
    task automatic drain;
        settle();
        repeat (8) @(negedge i_clk);
    endtask

    task automatic push_row(input logic [7:0][15:0] s, input logic fin);
        row_beat_t b;
        b.smp = s;
        b.fin = fin;
        row_queue = {row_queue, b};
        rows_sent++;
    endtask

    function automatic logic [15:0] pick_sample(input int style);
        case ($urandom_range(0, style))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random data set of n rows, the last one final.
    task automatic push_set(input int n, input int style);
        logic [7:0][15:0] s;
        for (int i = 0; i < n; i++) begin
            for (int d = 0; d < 8; d++) s[d] = pick_sample(style);
            push_row(s, i == n - 1);
        end
    endtask

    initial begin
        dims_cfg = DIMS_RESET;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes at the reset dimension count of eight.
        push_row({8{16'h7FFF}}, 1'b0);
        push_row({8{16'h8000}}, 1'b0);
        push_row({4{16'h7FFF, 16'h8000}}, 1'b0);
        push_row({8{16'h0000}}, 1'b1);
        push_row({8{16'h8000}}, 1'b1);
        push_row({4{16'hFFFF, 16'h0001}}, 1'b0);
        push_row({4{16'h0001, 16'hFFFF}}, 1'b1);
        drain();
        // Dimension count of zero acts as one, above eight acts as eight.
        write_dims(4'd0);
        push_set(3, 3);
        drain();
        write_dims(4'd15);
        push_set(3, 3);
        drain();
        write_dims(4'd1);
        push_set(2, 3);
        drain();
        write_dims(4'd8);
        push_set(3, 2);
        drain();

        // Random data sets, mostly small, with random dimension counts.
        while (rows_sent < 400) begin
            write_dims(($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(1, 8)));
            push_set(($urandom_range(0, 5) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(1, 12),
                     $urandom_range(3, 8));
            if ($urandom_range(0, 1)) drain();
            else settle();
            repeat (8) @(negedge i_clk);
        end

        // Closing stretch with no idling on either side.
        quiet = 1'b1;
        write_dims(4'd8);
        push_set(6, 4);
        push_set(1, 4);
        drain();
        write_dims(4'd3);
        push_set(5, 4);
        drain();

        repeat (100) @(posedge i_clk);
        if (cov_expect.size() != 0) report("expected entries never arrived");
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
